// ----- rtl/dntp_pkg.sv -----
package dntp_pkg;

   localparam int unsigned MAX_DIGITS = 19;
   localparam int unsigned LEN_BITS   = 16;
   localparam int unsigned KEPT_BITS  = 5;
   localparam int unsigned SCALE_BITS = 17;
   localparam int unsigned EXPV_BITS  = 14;
   localparam int unsigned EXP_BITS   = 16;
   localparam int unsigned SIG_BITS   = 64;
   localparam int unsigned EXP_MAX    = 9999;

   // negative, significand, dec_exponent, consumed, padded to whole bytes
   localparam int unsigned RSP_FIELDS_W = 1 + SIG_BITS + EXP_BITS + LEN_BITS;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_BEGIN = 7'b0000010,
      PH_INT   = 7'b0000100,
      PH_FRAC  = 7'b0001000,
      PH_E     = 7'b0010000,
      PH_ESIGN = 7'b0100000,
      PH_EDIG  = 7'b1000000
   } phase_type;

endpackage

// ----- rtl/decimal_number_text_parser.sv -----
// channel  | direction | tdata (low bit up)                          | tuser
// req_     | in        | ch[7:0]                                     | start_req
// rsp_     | out       | negative, significand[63:0], dec_exponent,  | ok
//          |           | consumed[15:0], zero pad to 104 bits        |
//
// One character is taken per cycle while req_tready is high; the result of the
// terminating character appears in the output register on the next cycle. The
// rate is set by the per-character multiply-by-ten-and-add on the 64-bit
// significand register. Synchronous reset leaves the parser idle, ignoring
// characters until a start. req_tready drops only while the output register
// holds a result that rsp_tready is not taking.
module decimal_number_text_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // ch
   input  logic                              req_tuser,   // start_req
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dntp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // negative, significand,
                                                          // dec_exponent, consumed
   output logic                              rsp_tuser    // ok
);
   import dntp_pkg::*;

   localparam logic [LEN_BITS-1:0]   LEN_MAX   = '1;
   localparam logic [SCALE_BITS-1:0] SCALE_MAX = {1'b0, {(SCALE_BITS-1){1'b1}}};
   localparam logic [SCALE_BITS-1:0] SCALE_MIN = {1'b1, {(SCALE_BITS-1){1'b0}}};

   phase_type                phase_ff, phase_in, ph;
   logic                     sign_ff, sign_in;
   logic [SIG_BITS-1:0]      acc_ff, acc_in;
   logic [KEPT_BITS-1:0]     kept_ff, kept_in;
   logic [SCALE_BITS-1:0]    scale_ff, scale_in;
   logic                     seen_ff, seen_in;
   logic [EXPV_BITS-1:0]     expv_ff, expv_in;
   logic                     expneg_ff, expneg_in;
   logic [LEN_BITS-1:0]      count_ff, count_in;
   logic [LEN_BITS-1:0]      mlen_ff, mlen_in;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic                     rsp_neg_ff, rsp_neg_in;
   logic [SIG_BITS-1:0]      rsp_sig_ff, rsp_sig_in;
   logic [EXP_BITS-1:0]      rsp_exp_ff, rsp_exp_in;
   logic [LEN_BITS-1:0]      rsp_len_ff, rsp_len_in;

   logic                     accept, emit;
   logic [7:0]               ch;
   logic                     is_digit, is_sign, is_e, is_dot;
   logic [3:0]               dig;
   logic                     c_sign, c_seen, c_expneg;
   logic [SIG_BITS-1:0]      c_acc, acc_x10;
   logic [KEPT_BITS-1:0]     c_kept;
   logic [SCALE_BITS-1:0]    c_scale;
   logic [EXPV_BITS-1:0]     c_expv;
   logic [LEN_BITS-1:0]      c_count, c_mlen, count_inc;
   logic                     acc_zero, kept_full;
   logic [EXPV_BITS+3:0]     expv_x10;
   logic [EXPV_BITS-1:0]     expv_next;
   logic signed [SCALE_BITS:0] e_sum;
   logic [EXP_BITS-1:0]      e_clamped;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   assign ch       = req_tdata;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_e     = (ch == CH_LOW_E) || (ch == CH_UP_E);
   assign is_dot   = (ch == CH_DOT);
   assign dig      = is_digit ? 4'(ch - CH_ZERO) : 4'd0;

   // a start clears the number before this character is taken
   assign ph       = req_tuser ? PH_BEGIN : phase_ff;
   assign c_sign   = req_tuser ? 1'b0 : sign_ff;
   assign c_acc    = req_tuser ? '0 : acc_ff;
   assign c_kept   = req_tuser ? '0 : kept_ff;
   assign c_scale  = req_tuser ? '0 : scale_ff;
   assign c_seen   = req_tuser ? 1'b0 : seen_ff;
   assign c_expv   = req_tuser ? '0 : expv_ff;
   assign c_expneg = req_tuser ? 1'b0 : expneg_ff;
   assign c_count  = req_tuser ? '0 : count_ff;
   assign c_mlen   = req_tuser ? '0 : mlen_ff;

   assign acc_x10   = (c_acc << 3) + (c_acc << 1) + SIG_BITS'(dig);
   assign acc_zero  = (c_acc == '0);
   assign kept_full = (c_kept >= KEPT_BITS'(MAX_DIGITS));
   assign count_inc = (c_count == LEN_MAX) ? c_count : c_count + 1'b1;
   assign expv_x10  = ((EXPV_BITS+4)'(c_expv) << 3) + ((EXPV_BITS+4)'(c_expv) << 1)
                    + (EXPV_BITS+4)'(dig);
   assign expv_next = (expv_x10 > (EXPV_BITS+4)'(EXP_MAX)) ? EXPV_BITS'(EXP_MAX)
                                                            : expv_x10[EXPV_BITS-1:0];

   always_comb begin
      e_sum = (SCALE_BITS+1)'(signed'(c_scale));
      if (ph == PH_EDIG) begin
         if (c_expneg) begin
            e_sum = e_sum - signed'((SCALE_BITS+1)'(c_expv));
         end else begin
            e_sum = e_sum + signed'((SCALE_BITS+1)'(c_expv));
         end
      end
      priority if (e_sum > (SCALE_BITS+1)'(32767)) begin
         e_clamped = 16'h7FFF;
      end else if (e_sum < -(SCALE_BITS+1)'(32768)) begin
         e_clamped = 16'h8000;
      end else begin
         e_clamped = e_sum[EXP_BITS-1:0];
      end
   end

   always_comb begin
      phase_in  = ph;
      sign_in   = c_sign;
      acc_in    = c_acc;
      kept_in   = c_kept;
      scale_in  = c_scale;
      seen_in   = c_seen;
      expv_in   = c_expv;
      expneg_in = c_expneg;
      count_in  = c_count;
      mlen_in   = c_mlen;
      emit      = 1'b0;
      unique case (ph)
         PH_IDLE: begin
         end
         PH_BEGIN: begin
            priority if (is_sign) begin
               sign_in  = (ch == CH_MINUS);
               count_in = count_inc;
               phase_in = PH_INT;
            end else if (is_digit) begin
               count_in = count_inc;
               phase_in = PH_INT;
            end else if (is_dot) begin
               count_in = count_inc;
               phase_in = PH_FRAC;
            end else begin
               emit = 1'b1;
            end
         end
         PH_INT: begin
            priority if (is_digit) begin
               count_in = count_inc;
            end else if (is_dot) begin
               count_in = count_inc;
               phase_in = PH_FRAC;
            end else if (is_e && c_seen) begin
               mlen_in  = c_count;
               count_in = count_inc;
               phase_in = PH_E;
            end else begin
               emit = 1'b1;
            end
         end
         PH_FRAC: begin
            priority if (is_digit) begin
               count_in = count_inc;
               seen_in  = 1'b1;
               if (!kept_full) begin
                  if (!(acc_zero && dig == 4'd0)) begin
                     acc_in  = acc_x10;
                     kept_in = c_kept + 1'b1;
                  end
                  if (c_scale != SCALE_MIN) begin
                     scale_in = c_scale - 1'b1;
                  end
               end
            end else if (is_e && c_seen) begin
               mlen_in  = c_count;
               count_in = count_inc;
               phase_in = PH_E;
            end else begin
               emit = 1'b1;
            end
         end
         PH_E: begin
            priority if (is_sign) begin
               expneg_in = (ch == CH_MINUS);
               count_in  = count_inc;
               phase_in  = PH_ESIGN;
            end else if (is_digit) begin
               expv_in  = expv_next;
               count_in = count_inc;
               phase_in = PH_EDIG;
            end else begin
               emit = 1'b1;
            end
         end
         PH_ESIGN, PH_EDIG: begin
            if (is_digit) begin
               expv_in  = expv_next;
               count_in = count_inc;
               phase_in = PH_EDIG;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // integer digit: shared by the begin and integer phases
      if ((ph == PH_BEGIN || ph == PH_INT) && is_digit) begin
         seen_in = 1'b1;
         if (!(acc_zero && dig == 4'd0)) begin
            if (!kept_full) begin
               acc_in  = acc_x10;
               kept_in = c_kept + 1'b1;
            end else if (c_scale != SCALE_MAX) begin
               scale_in = c_scale + 1'b1;
            end
         end
      end
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      rsp_ok_in  = c_seen;
      rsp_neg_in = c_seen && c_sign;
      rsp_sig_in = c_seen ? c_acc : '0;
      rsp_exp_in = c_seen ? e_clamped : '0;
      if (!c_seen) begin
         rsp_len_in = '0;
      end else if (ph == PH_E || ph == PH_ESIGN) begin
         rsp_len_in = c_mlen;
      end else begin
         rsp_len_in = c_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sign_ff   <= 1'b0;
         acc_ff    <= '0;
         kept_ff   <= '0;
         scale_ff  <= '0;
         seen_ff   <= 1'b0;
         expv_ff   <= '0;
         expneg_ff <= 1'b0;
         count_ff  <= '0;
         mlen_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         sign_ff   <= sign_in;
         acc_ff    <= acc_in;
         kept_ff   <= kept_in;
         scale_ff  <= scale_in;
         seen_ff   <= seen_in;
         expv_ff   <= expv_in;
         expneg_ff <= expneg_in;
         count_ff  <= count_in;
         mlen_ff   <= mlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ok_ff  <= rsp_ok_in;
         rsp_neg_ff <= rsp_neg_in;
         rsp_sig_ff <= rsp_sig_in;
         rsp_exp_ff <= rsp_exp_in;
         rsp_len_ff <= rsp_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_len_ff, rsp_exp_ff, rsp_sig_ff, rsp_neg_ff});

`ifndef SYNTHESIS
   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> phase_ff == PH_IDLE)
      else $error("parser not idle after result");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KEPT_BITS'(MAX_DIGITS))
      else $error("kept digit count beyond limit");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed result carries nonzero fields");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_FIELDS_W-1 -: LEN_BITS] != '0)
      else $error("valid number with zero length");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tuser && phase_ff == PH_IDLE |=> !rsp_tvalid || $stable(rsp_tdata))
      else $error("result from idle parser");
`endif

endmodule
